/* src/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check held off while reset is high
`define VGN_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also applies across reset
`define VGN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/vgn_pkg.sv */
// ----------------------------------------------------------------------------
// vgn_pkg
// Types and constants shared by the voxel gradient normal block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vgn_pkg;

   localparam int COORD_W = 6;
   localparam int SIZE_W  = 7;
   localparam int VOX_W   = 16;
   localparam int IDX_W   = 2;
   localparam int SUM_W   = 34;
   localparam int REM_W   = 35;
   localparam int QUO_W   = 31;
   localparam int ROOT_W  = 16;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   // neighbour read slots
   localparam logic [2:0] SLOT_C  = 3'd0;
   localparam logic [2:0] SLOT_XP = 3'd1;
   localparam logic [2:0] SLOT_XM = 3'd2;
   localparam logic [2:0] SLOT_YP = 3'd3;
   localparam logic [2:0] SLOT_YM = 3'd4;
   localparam logic [2:0] SLOT_ZP = 3'd5;
   localparam logic [2:0] SLOT_ZM = 3'd6;
   localparam int NUM_SLOTS = 7;

   typedef struct packed {
      logic       load;
      logic       addr1;
      logic       addr2;
      logic       mem_wr;
      logic       rd_en;
      logic [2:0] rd_sel;
      logic       diff;
      logic       sq;
      logic       div_init;
      logic       div_step;
      logic       div_first;
      logic       sqrt_step;
      logic [3:0] sqrt_bit;
      logic       save;
      logic [1:0] axis;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic is_write;
      logic in_range;
      logic s_zero;
   } status_type;

endpackage

/* src/vgn_ctrl.sv */
// ----------------------------------------------------------------------------
// vgn_ctrl
// Sequencer for address generation, neighbour reads, divide and root steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vgn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  vgn_pkg::status_type status,
   output vgn_pkg::cmd_type    cmd
);
   import vgn_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_ADDR1  = 4'd1;
   localparam logic [3:0] ST_ADDR2  = 4'd2;
   localparam logic [3:0] ST_DECIDE = 4'd3;
   localparam logic [3:0] ST_RD     = 4'd4;
   localparam logic [3:0] ST_DIFF   = 4'd5;
   localparam logic [3:0] ST_SQ     = 4'd6;
   localparam logic [3:0] ST_CHK    = 4'd7;
   localparam logic [3:0] ST_DINIT  = 4'd8;
   localparam logic [3:0] ST_DSTEP  = 4'd9;
   localparam logic [3:0] ST_SSTEP  = 4'd10;
   localparam logic [3:0] ST_SAVE   = 4'd11;
   localparam logic [3:0] ST_PUB    = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] axis_ff, axis_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      cmd.axis     = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ADDR1;
            end
         end
         ST_ADDR1: begin
            cmd.addr1 = 1'b1;
            state_in  = ST_ADDR2;
         end
         ST_ADDR2: begin
            cmd.addr2 = 1'b1;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            cnt_in = '0;
            priority if (status.is_write) begin
               cmd.mem_wr = status.in_range;
               state_in   = ST_IDLE;
            end else if (!status.in_range) begin
               state_in = ST_PUB;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = cnt_ff[2:0];
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff[2:0] == SLOT_ZM) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            cnt_in   = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.sq   = 1'b1;
            cmd.axis = cnt_ff[1:0];
            cnt_in   = cnt_ff + 5'd1;
            if (cnt_ff[1:0] == 2'd2) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            axis_in  = '0;
            state_in = status.s_zero ? ST_PUB : ST_DINIT;
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DSTEP;
         end
         ST_DSTEP: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (cnt_ff == 5'd0);
            cnt_in        = cnt_ff + 5'd1;
            if (cnt_ff == 5'(QUO_W - 1)) begin
               cnt_in   = 5'(ROOT_W - 1);
               state_in = ST_SSTEP;
            end
         end
         ST_SSTEP: begin
            cmd.sqrt_step = 1'b1;
            cmd.sqrt_bit  = cnt_ff[3:0];
            cnt_in        = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_SAVE;
            end
         end
         ST_SAVE: begin
            cmd.save = 1'b1;
            if (axis_ff == 2'd2) begin
               state_in = ST_PUB;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_DINIT;
            end
         end
         ST_PUB: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* src/vgn_datapath.sv */
// ----------------------------------------------------------------------------
// vgn_datapath
// Size registers, voxel memory, neighbour differences, divider and root unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vgn_datapath #(
   parameter int MAX_SIZE_X = 64,
   parameter int MAX_SIZE_Y = 64,
   parameter int MAX_SIZE_Z = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [vgn_pkg::IDX_W-1:0]          csr_index,
   input  logic [vgn_pkg::SIZE_W-1:0]         csr_wr_data,
   input  logic                               req_opcode,
   input  logic [vgn_pkg::COORD_W-1:0]        req_x_coord,
   input  logic [vgn_pkg::COORD_W-1:0]        req_y_coord,
   input  logic [vgn_pkg::COORD_W-1:0]        req_z_coord,
   input  logic signed [vgn_pkg::VOX_W-1:0]   req_voxel_value,
   input  vgn_pkg::cmd_type                   cmd,
   output vgn_pkg::status_type                status,
   output logic signed [vgn_pkg::VOX_W-1:0]   rsp_normal_x,
   output logic signed [vgn_pkg::VOX_W-1:0]   rsp_normal_y,
   output logic signed [vgn_pkg::VOX_W-1:0]   rsp_normal_z,
   output logic                               rsp_out_of_range
);
   import vgn_pkg::*;

   localparam int DEPTH = MAX_SIZE_X * MAX_SIZE_Y * MAX_SIZE_Z;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [SIZE_W-1:0] LIM_X = SIZE_W'((MAX_SIZE_X > 127) ? 127 : MAX_SIZE_X);
   localparam logic [SIZE_W-1:0] LIM_Y = SIZE_W'((MAX_SIZE_Y > 127) ? 127 : MAX_SIZE_Y);
   localparam logic [SIZE_W-1:0] LIM_Z = SIZE_W'((MAX_SIZE_Z > 127) ? 127 : MAX_SIZE_Z);

   logic [SIZE_W-1:0]  size_x_ff, size_y_ff, size_z_ff;
   logic               op_ff;
   logic [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic [VOX_W-1:0]   val_ff;
   logic [SIZE_W-1:0]  sx_ff, sy_ff, sz_ff;
   logic [AW-1:0]      tmp_ff, plane_ff, addr_ff;
   logic [AW-1:0]      rd_addr;
   logic [VOX_W-1:0]   mem [DEPTH];
   logic [VOX_W-1:0]   vox_ff [NUM_SLOTS];
   logic [ROOT_W-1:0]  mag_ff [3];
   logic [2:0]         neg_ff;
   logic [SUM_W-1:0]   s_ff;
   logic [REM_W-1:0]   r_ff, rr, rem_in;
   logic [QUO_W-1:0]   q_ff;
   logic               ge;
   logic [ROOT_W-1:0]  root_ff, t;
   logic [31:0]        tsq;
   logic [VOX_W-1:0]   res_ff [3];
   logic [VOX_W-1:0]   comp;
   logic [VOX_W-1:0]   nx_ff, ny_ff, nz_ff;
   logic               oor_ff;
   logic               xp_ok, xm_ok, yp_ok, ym_ok, zp_ok, zm_ok;
   logic               in_range;
   logic [VOX_W-1:0]   hi [3];
   logic [VOX_W-1:0]   lo [3];
   logic [VOX_W:0]     dif [3];

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_SIZE_X) size_x_ff <= csr_wr_data;
         if (csr_index == CSR_SIZE_Y) size_y_ff <= csr_wr_data;
         if (csr_index == CSR_SIZE_Z) size_z_ff <= csr_wr_data;
      end
   end

   assign in_range = ({1'b0, x_ff} < sx_ff) && ({1'b0, y_ff} < sy_ff) && ({1'b0, z_ff} < sz_ff);
   assign xp_ok  = ({1'b0, x_ff} + 7'd1) < sx_ff;
   assign yp_ok  = ({1'b0, y_ff} + 7'd1) < sy_ff;
   assign zp_ok  = ({1'b0, z_ff} + 7'd1) < sz_ff;
   assign xm_ok  = (x_ff != '0);
   assign ym_ok  = (y_ff != '0);
   assign zm_ok  = (z_ff != '0);

   assign status.is_write = (op_ff == OP_WRITE);
   assign status.in_range = in_range;
   assign status.s_zero   = (s_ff == '0);

   always_comb begin
      unique case (cmd.rd_sel)
         SLOT_XP: rd_addr = addr_ff + AW'(1);
         SLOT_XM: rd_addr = addr_ff - AW'(1);
         SLOT_YP: rd_addr = addr_ff + AW'(sx_ff);
         SLOT_YM: rd_addr = addr_ff - AW'(sx_ff);
         SLOT_ZP: rd_addr = addr_ff + plane_ff;
         SLOT_ZM: rd_addr = addr_ff - plane_ff;
         default: rd_addr = addr_ff;
      endcase
   end

   // voxel memory
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[addr_ff] <= val_ff;
      end
      if (cmd.rd_en) begin
         vox_ff[cmd.rd_sel] <= mem[rd_addr];
      end
   end

   always_comb begin
      hi[0] = xp_ok ? vox_ff[SLOT_XP] : vox_ff[SLOT_C];
      lo[0] = xm_ok ? vox_ff[SLOT_XM] : vox_ff[SLOT_C];
      hi[1] = yp_ok ? vox_ff[SLOT_YP] : vox_ff[SLOT_C];
      lo[1] = ym_ok ? vox_ff[SLOT_YM] : vox_ff[SLOT_C];
      hi[2] = zp_ok ? vox_ff[SLOT_ZP] : vox_ff[SLOT_C];
      lo[2] = zm_ok ? vox_ff[SLOT_ZM] : vox_ff[SLOT_C];
      for (int i = 0; i < 3; i++) begin
         dif[i] = {hi[i][VOX_W-1], hi[i]} - {lo[i][VOX_W-1], lo[i]};
      end
   end

   // restoring divide step and root bit test
   assign rr     = cmd.div_first ? r_ff : {r_ff[REM_W-2:0], 1'b0};
   assign ge     = rr >= {1'b0, s_ff};
   assign rem_in = ge ? (rr - {1'b0, s_ff}) : rr;
   assign t      = root_ff | (ROOT_W'(1) << cmd.sqrt_bit);
   assign tsq    = t * t;

   always_comb begin
      if (neg_ff[cmd.axis]) begin
         comp = ~root_ff + 16'd1;
      end else if (root_ff[ROOT_W-1]) begin
         comp = 16'h7FFF;
      end else begin
         comp = root_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         x_ff   <= req_x_coord;
         y_ff   <= req_y_coord;
         z_ff   <= req_z_coord;
         val_ff <= req_voxel_value;
         sx_ff  <= (size_x_ff > LIM_X) ? LIM_X : size_x_ff;
         sy_ff  <= (size_y_ff > LIM_Y) ? LIM_Y : size_y_ff;
         sz_ff  <= (size_z_ff > LIM_Z) ? LIM_Z : size_z_ff;
         for (int i = 0; i < 3; i++) res_ff[i] <= '0;
      end
      if (cmd.addr1) begin
         tmp_ff   <= AW'(y_ff) + AW'(sy_ff) * AW'(z_ff);
         plane_ff <= AW'(sx_ff) * AW'(sy_ff);
      end
      if (cmd.addr2) begin
         addr_ff <= AW'(x_ff) + AW'(sx_ff) * tmp_ff;
      end
      if (cmd.diff) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= dif[i][VOX_W];
            mag_ff[i] <= dif[i][VOX_W] ? VOX_W'(-dif[i]) : dif[i][VOX_W-1:0];
         end
         s_ff <= '0;
      end
      if (cmd.sq) begin
         s_ff <= s_ff + SUM_W'(mag_ff[cmd.axis] * mag_ff[cmd.axis]);
      end
      if (cmd.div_init) begin
         r_ff    <= REM_W'(mag_ff[cmd.axis] * mag_ff[cmd.axis]);
         q_ff    <= '0;
         root_ff <= '0;
      end
      if (cmd.div_step) begin
         r_ff <= rem_in;
         q_ff <= {q_ff[QUO_W-2:0], ge};
      end
      if (cmd.sqrt_step && (tsq <= {1'b0, q_ff})) begin
         root_ff <= t;
      end
      if (cmd.save) begin
         res_ff[cmd.axis] <= comp;
      end
      if (cmd.publish) begin
         nx_ff  <= res_ff[0];
         ny_ff  <= res_ff[1];
         nz_ff  <= res_ff[2];
         oor_ff <= ~in_range;
      end
   end

   assign rsp_normal_x     = nx_ff;
   assign rsp_normal_y     = ny_ff;
   assign rsp_normal_z     = nz_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

/* src/voxel_gradient_normal.sv */
// ----------------------------------------------------------------------------
// voxel_gradient_normal
// Voxel volume with a central difference unit surface normal query.
// ----------------------------------------------------------------------------
// Use: the req channel carries one transaction per write or query. A write
// (opcode 0) stores voxel_value at (x, y, z), packed x fastest with the sizes
// in force; coordinates outside the sizes are dropped and give no rsp.
// A query (opcode 1) gives one rsp transaction: the Q1.15 unit normal from
// the central differences, border neighbours replaced by the centre voxel.
// Out-of-range queries flag out_of_range with zero components.
// After a write is accepted, req_ready stays low through the address build
// and the write, so no new req is taken until it is done. A query runs the
// address build, seven reads from the single voxel memory port, and per axis
// a restoring divide and a root search on a shared unit, before rsp_valid.
// Out-of-range queries skip the reads; a zero gradient skips the divide.
// The user must write the size registers on the csr port only while idle;
// the block does not enforce it. Reset clears the sequencer and sets every
// size to 64; the voxel memory is not cleared and must be written before
// it is queried. A stalled rsp holds its payload; a new req is taken
// meanwhile and its result waits until the pending rsp transaction completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_gradient_normal #(
   parameter int MAX_SIZE_X = 64,
   parameter int MAX_SIZE_Y = 64,
   parameter int MAX_SIZE_Z = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [vgn_pkg::IDX_W-1:0]          csr_index,
   input  logic [vgn_pkg::SIZE_W-1:0]         csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [vgn_pkg::COORD_W-1:0]        req_x_coord,
   input  logic [vgn_pkg::COORD_W-1:0]        req_y_coord,
   input  logic [vgn_pkg::COORD_W-1:0]        req_z_coord,
   input  logic signed [vgn_pkg::VOX_W-1:0]   req_voxel_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [vgn_pkg::VOX_W-1:0]   rsp_normal_x,
   output logic signed [vgn_pkg::VOX_W-1:0]   rsp_normal_y,
   output logic signed [vgn_pkg::VOX_W-1:0]   rsp_normal_z,
   output logic                               rsp_out_of_range
);
   import vgn_pkg::*;

   cmd_type    cmd;
   status_type status;

   vgn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   vgn_datapath #(
      .MAX_SIZE_X (MAX_SIZE_X),
      .MAX_SIZE_Y (MAX_SIZE_Y),
      .MAX_SIZE_Z (MAX_SIZE_Z)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_opcode       (req_opcode),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_z_coord      (req_z_coord),
      .req_voxel_value  (req_voxel_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

/* src/vgn_checker.sv */
// ----------------------------------------------------------------------------
// vgn_checker
// Port-level checks on the voxel gradient normal block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vgn_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_normal_x,
   input logic [15:0] rsp_normal_y,
   input logic [15:0] rsp_normal_z,
   input logic        rsp_out_of_range
);

   `VGN_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "rsp valid after reset")

   `VGN_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_normal_x) && $stable(rsp_out_of_range), "stalled rsp changed")

   `VGN_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "req taken twice in a row")

   `VGN_ASSERT(a_oor_zero, clock, reset, rsp_valid && rsp_out_of_range |-> rsp_normal_x == 16'd0 && rsp_normal_y == 16'd0 && rsp_normal_z == 16'd0, "out of range rsp not zero")

endmodule

bind voxel_gradient_normal vgn_checker u_vgn_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_normal_x     (rsp_normal_x),
   .rsp_normal_y     (rsp_normal_y),
   .rsp_normal_z     (rsp_normal_z),
   .rsp_out_of_range (rsp_out_of_range)
);

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the voxel gradient normal block.
// ----------------------------------------------------------------------------
// Fills voxels ahead of every query so that only written voxels are read.
// A scoreboard keeps its own copy of the volume and the size registers and
// predicts each normal. Directed transactions cover saturation, both
// borders, out-of-range flags and degenerate sizes. Random phases then run
// under several size settings, with bursty requests, a stalling receiver, a
// long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import vgn_pkg::*;

   localparam int VOL_DEPTH   = 64 * 64 * 64;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE      = 200;

   typedef struct {
      logic signed [VOX_W-1:0] nx;
      logic signed [VOX_W-1:0] ny;
      logic signed [VOX_W-1:0] nz;
      logic                    oor;
   } normal_type;

   class normal_scoreboard;
      logic signed [VOX_W-1:0] volume [VOL_DEPTH];
      bit                      written [VOL_DEPTH];
      int unsigned             size_reg [3];
      normal_type              pending_normals [$];
      int                      failures;

      function new();
         size_reg = '{64, 64, 64};
         failures = 0;
      endfunction

      function int unsigned dim(int i);
         return (size_reg[i] > 64) ? 64 : size_reg[i];
      endfunction

      function bit in_volume(int unsigned x, int unsigned y, int unsigned z);
         return x < dim(0) && y < dim(1) && z < dim(2);
      endfunction

      function int unsigned addr(int unsigned x, int unsigned y, int unsigned z);
         return x + dim(0) * (y + dim(1) * z);
      endfunction

      function void set_size(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
         case (idx)
            CSR_SIZE_X: size_reg[0] = val;
            CSR_SIZE_Y: size_reg[1] = val;
            CSR_SIZE_Z: size_reg[2] = val;
            default: ;
         endcase
      endfunction

      function logic [VOX_W-1:0] q15(longint d, longint unsigned s);
         longint unsigned mag, target, q, t;
         longint          val;
         mag = (d < 0) ? -d : d;
         target = (mag * mag) << 30;
         q = 0;
         if ((64'd1 << 30) * s <= target) begin
            q = 32768;
         end else begin
            for (int b = 15; b >= 0; b--) begin
               t = q | (64'd1 << b);
               if (t * t * s <= target) q = t;
            end
         end
         val = (d < 0) ? -longint'(q) : longint'(q);
         if (val > 32767) val = 32767;
         return val[VOX_W-1:0];
      endfunction

      function void note_request(logic op, int unsigned x, int unsigned y, int unsigned z,
                                 logic signed [VOX_W-1:0] v);
         normal_type      n;
         longint          c, d [3];
         longint unsigned s;
         int unsigned     a, sx, sy, plane;
         a = addr(x, y, z);
         if (op == OP_WRITE) begin
            if (in_volume(x, y, z)) begin
               volume[a] = v;
               written[a] = 1;
            end
            return;
         end
         n = '{0, 0, 0, 0};
         if (!in_volume(x, y, z)) begin
            n.oor = 1;
         end else begin
            sx = dim(0);
            sy = dim(1);
            plane = sx * sy;
            c = volume[a];
            d[0] = ((x + 1 < sx) ? longint'(volume[a + 1]) : c)
                 - ((x > 0) ? longint'(volume[a - 1]) : c);
            d[1] = ((y + 1 < sy) ? longint'(volume[a + sx]) : c)
                 - ((y > 0) ? longint'(volume[a - sx]) : c);
            d[2] = ((z + 1 < dim(2)) ? longint'(volume[a + plane]) : c)
                 - ((z > 0) ? longint'(volume[a - plane]) : c);
            s = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
            if (s != 0) begin
               n.nx = q15(d[0], s);
               n.ny = q15(d[1], s);
               n.nz = q15(d[2], s);
            end
         end
         pending_normals.push_back(n);
      endfunction

      function void check_normal(normal_type got);
         normal_type want;
         if (pending_normals.size() == 0) begin
            $error("unexpected rsp transaction");
            failures++;
            return;
         end
         want = pending_normals.pop_front();
         if (got.nx !== want.nx) begin
            $error("normal_x: expected %0d, got %0d", want.nx, got.nx);
            failures++;
         end
         if (got.ny !== want.ny) begin
            $error("normal_y: expected %0d, got %0d", want.ny, got.ny);
            failures++;
         end
         if (got.nz !== want.nz) begin
            $error("normal_z: expected %0d, got %0d", want.nz, got.nz);
            failures++;
         end
         if (got.oor !== want.oor) begin
            $error("out_of_range: expected %0d, got %0d", want.oor, got.oor);
            failures++;
         end
      endfunction
   endclass

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      csr_wr_en = 0;
   logic [IDX_W-1:0]          csr_index = '0;
   logic [SIZE_W-1:0]         csr_wr_data = '0;
   logic                      req_valid = 0;
   logic                      req_ready;
   logic                      req_opcode = OP_WRITE;
   logic [COORD_W-1:0]        req_x_coord = '0;
   logic [COORD_W-1:0]        req_y_coord = '0;
   logic [COORD_W-1:0]        req_z_coord = '0;
   logic signed [VOX_W-1:0]   req_voxel_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 0;
   logic signed [VOX_W-1:0]   rsp_normal_x;
   logic signed [VOX_W-1:0]   rsp_normal_y;
   logic signed [VOX_W-1:0]   rsp_normal_z;
   logic                      rsp_out_of_range;

   normal_scoreboard sb = new();
   int               hold_off = 0;
   int               burst_left = 0;
   bit               steady_mode = 0;
   int               cycle_count = 0;

   voxel_gradient_normal DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_x_coord(req_x_coord), .req_y_coord(req_y_coord), .req_z_coord(req_z_coord),
      .req_voxel_value(req_voxel_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_out_of_range(rsp_out_of_range)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: stall pattern follows bit 9 of the cycle count, hold-off overrides it
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_normal('{rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_out_of_range});
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 0;
      end else if (cycle_count[9]) begin
         rsp_ready <= 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic send(logic op, int unsigned x, int unsigned y, int unsigned z,
                       logic signed [VOX_W-1:0] v);
      int gap;
      gap = 0;
      if (!steady_mode) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
      end
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_x_coord <= COORD_W'(x);
      req_y_coord <= COORD_W'(y);
      req_z_coord <= COORD_W'(z);
      req_voxel_value <= v;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, x, y, z, v);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending_normals.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_size(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
      drain();
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.set_size(idx, val);
      @(posedge clock);
   endtask

   task automatic set_sizes(int sx, int sy, int sz);
      write_size(CSR_SIZE_X, SIZE_W'(sx));
      write_size(CSR_SIZE_Y, SIZE_W'(sy));
      write_size(CSR_SIZE_Z, SIZE_W'(sz));
   endtask

   // write any unwritten voxel the query will read, then issue the query
   task automatic prepared_query(int unsigned x, int unsigned y, int unsigned z);
      int offs [7][3];
      int px, py, pz;
      offs = '{'{0, 0, 0}, '{1, 0, 0}, '{-1, 0, 0}, '{0, 1, 0}, '{0, -1, 0},
               '{0, 0, 1}, '{0, 0, -1}};
      if (sb.in_volume(x, y, z)) begin
         foreach (offs[i]) begin
            px = x + offs[i][0];
            py = y + offs[i][1];
            pz = z + offs[i][2];
            if (px < 0 || px >= sb.dim(0)) px = x;
            if (py < 0 || py >= sb.dim(1)) py = y;
            if (pz < 0 || pz >= sb.dim(2)) pz = z;
            if (!sb.written[sb.addr(px, py, pz)])
               send(OP_WRITE, px, py, pz, VOX_W'($urandom));
         end
      end
      send(OP_QUERY, x, y, z, VOX_W'($urandom));
   endtask

   task automatic random_phase(int count, bit squeeze);
      int unsigned x, y, z;
      for (int i = 0; i < count; i++) begin
         if (squeeze && i == count / 3) hold_off = 600;
         if (squeeze && i == 2 * count / 3) drain();
         if (i % 40 == 0) steady_mode = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 9) < 8) begin
            x = $urandom_range(0, sb.dim(0) == 0 ? 0 : sb.dim(0) - 1);
            y = $urandom_range(0, sb.dim(1) == 0 ? 0 : sb.dim(1) - 1);
            z = $urandom_range(0, sb.dim(2) == 0 ? 0 : sb.dim(2) - 1);
         end else begin
            x = $urandom_range(0, 63);
            y = $urandom_range(0, 63);
            z = $urandom_range(0, 63);
         end
         if ($urandom_range(0, 3) == 0)
            send(OP_WRITE, x, y, z, VOX_W'($urandom));
         else
            prepared_query(x, y, z);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      prepared_query(0, 0, 0);
      prepared_query(63, 63, 63);
      send(OP_WRITE, 63, 0, 0, 16'sh7fff);
      send(OP_WRITE, 62, 0, 0, 16'sh8000);
      prepared_query(63, 0, 0);

      set_sizes(1, 1, 3);
      send(OP_WRITE, 0, 0, 0, 16'sh8000);
      send(OP_WRITE, 0, 0, 1, 16'sh0000);
      send(OP_WRITE, 0, 0, 2, 16'sh7fff);
      send(OP_QUERY, 0, 0, 1, 0);
      send(OP_QUERY, 0, 0, 0, 0);
      send(OP_WRITE, 0, 0, 0, 16'sh7fff);
      send(OP_WRITE, 0, 0, 2, 16'sh8000);
      send(OP_QUERY, 0, 0, 1, 0);
      send(OP_WRITE, 0, 0, 2, 16'sh7fff);
      send(OP_QUERY, 0, 0, 2, 0);
      send(OP_WRITE, 1, 0, 0, 16'sh1234);
      send(OP_QUERY, 1, 0, 0, 0);
      send(OP_QUERY, 0, 0, 3, 0);

      write_size(CSR_SIZE_X, 7'd0);
      send(OP_WRITE, 0, 0, 0, 16'sh5555);
      send(OP_QUERY, 0, 0, 0, 0);
      write_size(2'd3, 7'd5);
      write_size(CSR_SIZE_X, 7'd127);
      prepared_query(63, 0, 1);
      send(OP_QUERY, 0, 1, 0, 0);

      set_sizes(64, 64, 64);
      random_phase(50, 1);
      set_sizes(1, 1, 1);
      random_phase(20, 0);
      set_sizes(127, 5, 3);
      random_phase(40, 0);
      set_sizes(2, 64, 0);
      random_phase(15, 0);
      set_sizes(3, 2, 64);
      random_phase(40, 0);
      set_sizes($urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(1, 20));
      random_phase(40, 1);
      set_sizes(64, 1, 100);
      random_phase(40, 0);

      drain();
      if (sb.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
